FILE: rtl/thht_pkg.sv
// shared constants and codes for the trilateration hoop hit test
`timescale 1ns / 1ps

package thht_pkg;

  // default field width and fraction width of the q-format distances
  localparam int DIST_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF = 8;

  // reset values as fractions: 12.4 m, 3.05 m, 0.4572 m
  localparam longint BASE_NUM   = 124;
  localparam longint BASE_DEN   = 10;
  localparam longint HOOPY_NUM  = 305;
  localparam longint HOOPY_DEN  = 100;
  localparam longint RADIUS_NUM = 4572;
  localparam longint RADIUS_DEN = 10000;

  // configuration register indexes
  localparam int REG_IDX_BITS = 2;
  typedef enum logic [REG_IDX_BITS-1:0] {
    REG_BASELINE = 2'd0,
    REG_HOOP_X   = 2'd1,
    REG_HOOP_Y   = 2'd2,
    REG_RADIUS   = 2'd3
  } reg_idx_t;

  // result flag positions in m_tuser
  localparam int USER_BITS   = 4;
  localparam int U_NO_FIX    = 0;
  localparam int U_X_CLIPPED = 1;
  localparam int U_IN_HOOP   = 2;
  localparam int U_SCORED    = 3;

endpackage

FILE: rtl/trilateration_hoop_hit_test.sv
// two-anchor trilateration with hoop hit test, bit-serial datapath
// seven squarings on one shift-add multiplier, a restoring divide and a digit-by-digit square root
// no fix skips the root and hoop squarings, a clipped x the hoop squarings, zero baseline the divide
// one item in flight: a new beat is taken in the cycle after the result is registered;
//   a waiting result stalls only the next result
// rst (synchronous) clears control, hit_seen and the output valid, and loads register defaults
`timescale 1ns / 1ps

module trilateration_hoop_hit_test #(
  parameter int DIST_BITS = thht_pkg::DIST_BITS_DEF,
  parameter int FRAC_BITS = thht_pkg::FRAC_BITS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst,
  // input beat
  input  logic                                    s_tvalid,
  output logic                                    s_tready,
  input  logic [((2*DIST_BITS+7)/8)*8-1:0]        s_tdata,   // dist1, dist2
  input  logic                                    s_tlast,   // last_sample
  // result beat
  output logic                                    m_tvalid,
  input  logic                                    m_tready,
  output logic [((2*DIST_BITS+7)/8)*8-1:0]        m_tdata,   // pos_x, pos_y
  output logic [thht_pkg::USER_BITS-1:0]          m_tuser,   // no_fix, x_clipped,
                                                             // point_in_hoop, scored
  output logic                                    m_tlast,   // trajectory_end
  // register writes
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [thht_pkg::REG_IDX_BITS-1:0]       cfg_addr,
  input  logic [DIST_BITS-1:0]                    cfg_data
);

  import thht_pkg::*;

  localparam int D   = DIST_BITS;
  localparam int W   = D + 1;          // multiplier operand width
  localparam int P   = 2 * W;          // product width
  localparam int N2  = 2 * D;          // square width
  localparam int TDW = ((2 * D + 7) / 8) * 8;
  localparam int CW  = $clog2(2 * D + 1);

  // rounded reset values in the configured fraction width
  localparam longint RST_BASE   = ((BASE_NUM << FRAC_BITS) + BASE_DEN / 2) / BASE_DEN;
  localparam longint RST_HOOPY  = ((HOOPY_NUM << FRAC_BITS) + HOOPY_DEN / 2) / HOOPY_DEN;
  localparam longint RST_RADIUS = ((RADIUS_NUM << FRAC_BITS) + RADIUS_DEN / 2) / RADIUS_DEN;

  localparam logic [D-1:0] XMAX     = {1'b0, {(D-1){1'b1}}};
  localparam logic [D-1:0] XMIN_MAG = {1'b1, {(D-1){1'b0}}};

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_MDONE, S_MAG, S_DIV, S_FIX, S_SQRT, S_HOOP, S_OUT
  } state_t;

  // which square the multiplier is working on
  typedef enum logic [2:0] {
    OP_D1, OP_D2, OP_L, OP_X, OP_AX, OP_AY, OP_R
  } op_t;

  state_t        state;
  op_t           op;
  logic [CW-1:0] cnt;

  // configuration
  logic [D-1:0] baseline, hoop_x, hoop_y, radius;
  logic         hit_seen;

  // captured input
  logic [D-1:0] d2;
  logic         last;

  // shift-add multiplier
  logic [W-1:0] mcand, mplier;
  logic [P-1:0] acc;

  // working values
  logic [N2-1:0] s1;       // dist1 squared
  logic [P:0]    part;     // dist2 squared, later sum of hoop squares
  logic [N2:0]   sh;       // p, then dividend, then radicand, shifted out msb first
  logic          neg;
  logic [D:0]    rem;      // divide remainder
  logic [D-1:0]  q;
  logic          ovf;      // quotient bits above the x range
  logic [D:0]    srem;     // root remainder
  logic [D-1:0]  root;
  logic [D-1:0]  x;
  logic          clip, nofix, inh;
  logic [D-1:0]  ay;

  // combinational step logic
  logic [P-1:0]  acc_step;
  logic [D+1:0]  rem_sh, dvs, rem_dif;
  logic          div_ge;
  logic [D:0]    rem_new;
  logic [D+2:0]  sq_sh, trial, sq_dif;
  logic          sq_ge;
  logic [D:0]    srem_new;
  logic [D:0]    qc;
  logic          fclip;
  logic [D-1:0]  fxm, fx;
  logic [N2:0]   xdif;
  logic [N2:0]   s2_ext, p_minus, s_minus;
  logic          mag_neg;
  logic [D+1:0]  xs, hx, dxa, dxb;
  logic [D:0]    ax_c;
  logic [D-1:0]  ay_c;
  logic [TDW-1:0] out_word;
  logic [USER_BITS-1:0] out_user;
  logic          sc;
  logic          out_free;

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !m_tvalid || m_tready;

  always_comb begin
    // one multiplier bit per cycle, msb first
    acc_step = {acc[P-2:0], 1'b0} + (mplier[W-1] ? {{(P-W){1'b0}}, mcand} : '0);

    // restoring divide by 2*baseline, one quotient bit per cycle
    rem_sh  = {rem, sh[N2]};
    dvs     = {1'b0, baseline, 1'b0};
    div_ge  = (rem_sh >= dvs);
    rem_dif = rem_sh - dvs;
    rem_new = div_ge ? rem_dif[D:0] : rem_sh[D:0];

    // square root, two radicand bits per cycle
    sq_sh    = {srem, sh[N2-1:N2-2]};
    trial    = {1'b0, root, 2'b01};
    sq_ge    = (sq_sh >= trial);
    sq_dif   = sq_sh - trial;
    srem_new = sq_ge ? sq_dif[D:0] : sq_sh[D:0];

    // quotient to saturated x; negative side rounds toward minus infinity
    qc = {1'b0, q} + {{D{1'b0}}, (rem != '0)};
    if (baseline == '0) begin
      fclip = 1'b1;
      fxm   = neg ? XMIN_MAG : XMAX;
    end else if (!neg) begin
      fclip = ovf || q[D-1];
      fxm   = fclip ? XMAX : q;
    end else begin
      fclip = ovf || (qc > {1'b0, XMIN_MAG});
      fxm   = fclip ? XMIN_MAG : qc[D-1:0];
    end
    fx = neg ? ('0 - fxm) : fxm;

    // borrow out marks a negative radicand
    xdif = {1'b0, s1} - {1'b0, acc[N2-1:0]};

    // |p - s2| with its sign
    s2_ext  = {1'b0, part[N2-1:0]};
    mag_neg = (sh < s2_ext);
    p_minus = sh - s2_ext;
    s_minus = s2_ext - sh;

    // distances to the hoop centre
    xs   = {{2{x[D-1]}}, x};
    hx   = {2'b00, hoop_x};
    dxa  = xs - hx;
    dxb  = hx - xs;
    ax_c = dxa[D+1] ? dxb[D:0] : dxa[D:0];
    ay_c = (root >= hoop_y) ? (root - hoop_y) : (hoop_y - root);

    sc = hit_seen || inh;

    out_word           = '0;
    out_word[D-1:0]    = x;
    out_word[N2-1:D]   = root;
    out_user              = '0;
    out_user[U_NO_FIX]    = nofix;
    out_user[U_X_CLIPPED] = clip;
    out_user[U_IN_HOOP]   = inh;
    out_user[U_SCORED]    = sc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      op          <= OP_D1;
      cnt         <= '0;
      m_tvalid    <= 1'b0;
      hit_seen    <= 1'b0;
      baseline    <= D'(RST_BASE);
      hoop_x      <= D'(RST_BASE);
      hoop_y      <= D'(RST_HOOPY);
      radius      <= D'(RST_RADIUS);
    end else begin
      // register writes must arrive only while idle; the block itself does not enforce this
      if (cfg_valid) begin
        case (reg_idx_t'(cfg_addr))
          REG_BASELINE: baseline <= cfg_data;
          REG_HOOP_X:   hoop_x   <= cfg_data;
          REG_HOOP_Y:   hoop_y   <= cfg_data;
          REG_RADIUS:   radius   <= cfg_data;
          default: ;
        endcase
      end

      // a finished item in S_OUT loads the output register instead
      if (m_tready && !(state == S_OUT && out_free)) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            d2     <= s_tdata[N2-1:D];
            last   <= s_tlast;
            mcand  <= {1'b0, s_tdata[D-1:0]};
            mplier <= {1'b0, s_tdata[D-1:0]};
            acc    <= '0;
            cnt    <= CW'(W - 1);
            op     <= OP_D1;
            state  <= S_MUL;
          end
        end

        S_MUL: begin
          acc    <= acc_step;
          mplier <= {mplier[W-2:0], 1'b0};
          if (cnt == '0) begin
            state <= S_MDONE;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end

        S_MDONE: begin
          case (op)
            OP_D1: begin
              s1     <= acc[N2-1:0];
              mcand  <= {1'b0, d2};
              mplier <= {1'b0, d2};
              acc    <= '0;
              cnt    <= CW'(W - 1);
              op     <= OP_D2;
              state  <= S_MUL;
            end
            OP_D2: begin
              part   <= {1'b0, acc};
              mcand  <= {1'b0, baseline};
              mplier <= {1'b0, baseline};
              acc    <= '0;
              cnt    <= CW'(W - 1);
              op     <= OP_L;
              state  <= S_MUL;
            end
            OP_L: begin
              sh    <= {1'b0, s1} + {1'b0, acc[N2-1:0]};
              state <= S_MAG;
            end
            OP_X: begin
              nofix <= xdif[N2];
              sh    <= {1'b0, xdif[N2-1:0]};
              srem  <= '0;
              root  <= '0;
              cnt   <= CW'(D - 1);
              if (xdif[N2]) begin
                inh   <= 1'b0;
                state <= S_OUT;
              end else begin
                state <= S_SQRT;
              end
            end
            OP_AX: begin
              part   <= {1'b0, acc};
              mcand  <= {1'b0, ay};
              mplier <= {1'b0, ay};
              acc    <= '0;
              cnt    <= CW'(W - 1);
              op     <= OP_AY;
              state  <= S_MUL;
            end
            OP_AY: begin
              part   <= part + {1'b0, acc};
              mcand  <= {1'b0, radius};
              mplier <= {1'b0, radius};
              acc    <= '0;
              cnt    <= CW'(W - 1);
              op     <= OP_R;
              state  <= S_MUL;
            end
            OP_R: begin
              inh   <= (part <= {1'b0, acc});
              state <= S_OUT;
            end
            default: state <= S_IDLE;
          endcase
        end

        S_MAG: begin
          neg   <= mag_neg;
          sh    <= mag_neg ? s_minus : p_minus;
          rem   <= '0;
          q     <= '0;
          ovf   <= 1'b0;
          cnt   <= CW'(2 * D);
          // zero baseline saturates without dividing
          state <= (baseline == '0) ? S_FIX : S_DIV;
        end

        S_DIV: begin
          rem <= rem_new;
          q   <= {q[D-2:0], div_ge};
          ovf <= ovf || q[D-1];
          sh  <= {sh[N2-1:0], 1'b0};
          if (cnt == '0) begin
            state <= S_FIX;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end

        S_FIX: begin
          x      <= fx;
          clip   <= fclip;
          mcand  <= {1'b0, fxm};
          mplier <= {1'b0, fxm};
          acc    <= '0;
          cnt    <= CW'(W - 1);
          op     <= OP_X;
          state  <= S_MUL;
        end

        S_SQRT: begin
          srem <= srem_new;
          root <= {root[D-2:0], sq_ge};
          sh   <= {sh[N2-2:0], 2'b00};
          if (cnt == '0) begin
            if (clip) begin
              inh   <= 1'b0;
              state <= S_OUT;
            end else begin
              state <= S_HOOP;
            end
          end else begin
            cnt <= cnt - 1'b1;
          end
        end

        S_HOOP: begin
          ay     <= ay_c;
          mcand  <= ax_c;
          mplier <= ax_c;
          acc    <= '0;
          cnt    <= CW'(W - 1);
          op     <= OP_AX;
          state  <= S_MUL;
        end

        S_OUT: begin
          // hold here while the previous result still waits
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= out_word;
            m_tuser  <= out_user;
            m_tlast  <= last;
            hit_seen <= last ? 1'b0 : sc;
            state    <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/thht_chk.sv
// port-level checker for the trilateration hoop hit test, with its bind
`timescale 1ns / 1ps

module thht_chk #(
  parameter int DIST_BITS = thht_pkg::DIST_BITS_DEF
) (
  input logic                                clk,
  input logic                                rst,
  input logic                                s_tvalid,
  input logic                                s_tready,
  input logic                                m_tvalid,
  input logic                                m_tready,
  input logic [((2*DIST_BITS+7)/8)*8-1:0]    m_tdata,
  input logic [thht_pkg::USER_BITS-1:0]      m_tuser,
  input logic                                m_tlast
);

  import thht_pkg::*;

  // a scored trajectory stays scored until its last beat
  logic sc_open;

  always_ff @(posedge clk) begin
    if (rst) begin
      sc_open <= 1'b0;
    end else if (m_tvalid && m_tready) begin
      sc_open <= m_tuser[U_SCORED] && !m_tlast;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=>
      m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
    else $error("result beat changed while stalled");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second item taken while one is in flight");

  a_hit_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[U_IN_HOOP] |->
      !m_tuser[U_NO_FIX] && !m_tuser[U_X_CLIPPED] && m_tuser[U_SCORED])
    else $error("hoop hit on an invalid point or without scored");

  a_sticky: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && sc_open |-> m_tuser[U_SCORED])
    else $error("scored dropped inside a trajectory");

endmodule

bind trilateration_hoop_hit_test thht_chk #(.DIST_BITS(DIST_BITS)) u_thht_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
